@@ src/assert_macros.svh @@
// Assertion macros for the running median block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed: %m");
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: %m");
`else
`define AST_ALWAYS(lbl, clk, rst_n, expr)
`define AST_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/rmth_pkg.sv @@
// Shared types for the running median block: state encodings and heap control.
// No dependencies.
package rmth_pkg;

    typedef enum logic [1:0] {
        HOP_NONE,
        HOP_PUSH,
        HOP_POP
    } t_heap_op;

    typedef struct packed {
        t_heap_op op;
        logic     clear;
    } t_heap_ctl;

    typedef enum logic [2:0] {
        H_IDLE,
        H_UP_RD,
        H_UP_CMP,
        H_DN_LAST,
        H_DN_RD,
        H_DN_CMP
    } t_heap_state;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_PUSH1,
        S_BAL,
        S_POP,
        S_PUSH2,
        S_FIN
    } t_top_state;

endpackage

@@ src/running_median_two_heaps.sv @@
// Running median engine: top level with the control sequencer and output register.
// Depends on rmth_pkg, rmth_heap and assert_macros.svh.
//
// Each word carries a sample and a restart flag; each accepted word yields one result
// word with the median of the samples held, the held count and a dropped flag. Words
// are handled one at a time. An item takes a push into one heap, and when the balance
// breaks a pop from that heap and a push into the other; each heap walk takes a read
// step and then a compare and write step per level of the heap memory. A dropped
// sample skips the heaps. A result waits in its output register while the next word
// is taken.
`include "assert_macros.svh"
module running_median_two_heaps #(
    parameter int CAPACITY     = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_sample,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_median,
    output logic [6:0]  o_held_count,
    output logic        o_dropped
);
    import rmth_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int DEPTH = CAPACITY / 2 + 2;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int HW    = CW + 1;

    t_top_state r_state, n_state;
    logic signed [SW-1:0] r_x, n_x;
    logic r_tolow, n_tolow, r_drop, n_drop;
    logic r_ovalid, n_ovalid;
    logic r_odrop, n_odrop;
    logic signed [31:0] r_med, n_med;
    logic [6:0] r_held, n_held;

    t_heap_ctl lo_ctl, up_ctl;
    logic signed [SW-1:0] lo_val, up_val, lo_top, up_top, lo_pop, up_pop;
    logic lo_done, up_done;
    logic [CW-1:0] lo_cnt, up_cnt;

    logic [HW-1:0] lc, uc, held;
    logic signed [SW:0] sum, half;
    logic signed [SW-1:0] med;
    logic [31:0] held32;

    rmth_heap #(.DEPTH(DEPTH), .SW(SW), .CW(CW), .IS_MAX(1'b1)) u_lower (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(lo_ctl), .i_val(lo_val),
        .o_done(lo_done), .o_top(lo_top), .o_pop(lo_pop), .o_count(lo_cnt)
    );

    rmth_heap #(.DEPTH(DEPTH), .SW(SW), .CW(CW), .IS_MAX(1'b0)) u_upper (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(up_ctl), .i_val(up_val),
        .o_done(up_done), .o_top(up_top), .o_pop(up_pop), .o_count(up_cnt)
    );

    assign lc     = HW'(lo_cnt);
    assign uc     = HW'(up_cnt);
    assign held   = lc + uc;
    assign held32 = 32'(held);
    assign sum    = (SW+1)'(lo_top) + (SW+1)'(up_top);
    assign half   = (sum + (SW+1)'(sum < 0)) >>> 1;
    assign med    = (lc > uc || uc == '0) ? lo_top : half[SW-1:0];

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_tolow  = r_tolow;
        n_drop   = r_drop;
        n_ovalid = r_ovalid;
        n_odrop  = r_odrop;
        n_med    = r_med;
        n_held   = r_held;
        lo_ctl   = '{op: HOP_NONE, clear: 1'b0};
        up_ctl   = '{op: HOP_NONE, clear: 1'b0};
        lo_val   = r_x;
        up_val   = r_x;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_x          = i_sample[SW-1:0];
                    lo_ctl.clear = i_restart;
                    up_ctl.clear = i_restart;
                    n_state      = S_DEC;
                end
            end
            S_DEC: begin
                if (held >= HW'(CAPACITY)) begin
                    n_drop  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_drop  = 1'b0;
                    n_tolow = (lc == '0) || (r_x < lo_top);
                    if ((lc == '0) || (r_x < lo_top)) begin
                        lo_ctl.op = HOP_PUSH;
                    end else begin
                        up_ctl.op = HOP_PUSH;
                    end
                    n_state = S_PUSH1;
                end
            end
            S_PUSH1: begin
                if (r_tolow ? lo_done : up_done) begin
                    n_state = S_BAL;
                end
            end
            S_BAL: begin
                if (r_tolow && (uc + HW'(1) < lc)) begin
                    lo_ctl.op = HOP_POP;
                    n_state   = S_POP;
                end else if (!r_tolow && (uc > lc)) begin
                    up_ctl.op = HOP_POP;
                    n_state   = S_POP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_POP: begin
                if (r_tolow && lo_done) begin
                    up_ctl.op = HOP_PUSH;
                    up_val    = lo_pop;
                    n_state   = S_PUSH2;
                end else if (!r_tolow && up_done) begin
                    lo_ctl.op = HOP_PUSH;
                    lo_val    = up_pop;
                    n_state   = S_PUSH2;
                end
            end
            S_PUSH2: begin
                if (r_tolow ? up_done : lo_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_odrop  = r_drop;
                    n_med    = 32'(med);
                    n_held   = held32[6:0];
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_x     <= n_x;
        r_tolow <= n_tolow;
        r_drop  <= n_drop;
        r_odrop <= n_odrop;
        r_med   <= n_med;
        r_held  <= n_held;
    end

    assign o_valid      = r_ovalid;
    assign o_median     = r_med;
    assign o_held_count = r_held;
    assign o_dropped    = r_odrop;

    `AST_ALWAYS(a_cap, i_clk, i_rst_n, held <= HW'(CAPACITY))
    `AST_ALWAYS(a_bal, i_clk, i_rst_n, !(r_state == S_IDLE) || lc == uc || lc == uc + HW'(1))
    `AST_NEXT(a_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

endmodule

@@ src/rmth_heap.sv @@
// One binary heap held in a two-read, one-write synchronous memory.
// Push sifts a hole up, pop sifts a hole down; depends on rmth_pkg.
module rmth_heap #(
    parameter int DEPTH = 34,
    parameter int SW    = 32,
    parameter int CW    = 6,
    parameter bit IS_MAX = 1'b1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rmth_pkg::t_heap_ctl i_ctl,
    input  logic signed [SW-1:0] i_val,
    output logic                o_done,
    output logic signed [SW-1:0] o_top,
    output logic signed [SW-1:0] o_pop,
    output logic [CW-1:0]       o_count
);
    import rmth_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int IW = CW + 1;

    logic signed [SW-1:0] mem [DEPTH];
    logic signed [SW-1:0] r_rd0, r_rd1;
    logic [AW-1:0] raddr0, raddr1, waddr;
    logic          we;
    logic signed [SW-1:0] wdata;

    t_heap_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_i, n_i;
    logic signed [SW-1:0] r_v, n_v, r_top, n_top, r_pop, n_pop;

    logic [IW-1:0] par, lch, rch, cnt_w, nm1;
    logic lsel, rsel;
    logic signed [SW-1:0] bestv;

    function automatic logic above(logic signed [SW-1:0] a, logic signed [SW-1:0] b);
        return IS_MAX ? (a > b) : (a < b);
    endfunction

    assign cnt_w = IW'(r_cnt);
    assign nm1   = cnt_w - IW'(1);
    assign par   = (r_i - IW'(1)) >> 1;
    assign lch   = (r_i << 1) + IW'(1);
    assign rch   = (r_i << 1) + IW'(2);
    assign lsel  = (lch < cnt_w) && above(r_rd0, r_v);
    assign bestv = lsel ? r_rd0 : r_v;
    assign rsel  = (rch < cnt_w) && above(r_rd1, bestv);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_v     = r_v;
        n_top   = r_top;
        n_pop   = r_pop;
        raddr0  = '0;
        raddr1  = '0;
        waddr   = r_i[AW-1:0];
        wdata   = r_v;
        we      = 1'b0;
        o_done  = 1'b0;
        unique case (r_state)
            H_IDLE: begin
                if (i_ctl.clear) begin
                    n_cnt = '0;
                end else if (i_ctl.op == HOP_PUSH) begin
                    n_cnt   = r_cnt + CW'(1);
                    n_i     = cnt_w;
                    n_v     = i_val;
                    n_state = H_UP_RD;
                end else if (i_ctl.op == HOP_POP) begin
                    n_pop   = r_top;
                    n_cnt   = r_cnt - CW'(1);
                    raddr0  = nm1[AW-1:0];
                    n_state = H_DN_LAST;
                end
            end
            H_UP_RD: begin
                if (r_i == '0) begin
                    we      = 1'b1;
                    n_top   = r_v;
                    o_done  = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    raddr0  = par[AW-1:0];
                    n_state = H_UP_CMP;
                end
            end
            H_UP_CMP: begin
                we = 1'b1;
                if (above(r_v, r_rd0)) begin
                    wdata   = r_rd0;
                    n_i     = par;
                    n_state = H_UP_RD;
                end else begin
                    o_done  = 1'b1;
                    n_state = H_IDLE;
                end
            end
            H_DN_LAST: begin
                n_v = r_rd0;
                n_i = '0;
                if (r_cnt == '0) begin
                    o_done  = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    n_state = H_DN_RD;
                end
            end
            H_DN_RD: begin
                raddr0  = lch[AW-1:0];
                raddr1  = rch[AW-1:0];
                n_state = H_DN_CMP;
            end
            H_DN_CMP: begin
                we = 1'b1;
                if (rsel) begin
                    wdata   = r_rd1;
                    n_i     = rch;
                    n_state = H_DN_RD;
                end else if (lsel) begin
                    wdata   = r_rd0;
                    n_i     = lch;
                    n_state = H_DN_RD;
                end else begin
                    o_done  = 1'b1;
                    n_state = H_IDLE;
                end
                if (r_i == '0) begin
                    n_top = wdata;
                end
            end
            default: n_state = H_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd0 <= mem[raddr0];
        r_rd1 <= mem[raddr1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_i   <= n_i;
        r_v   <= n_v;
        r_top <= n_top;
        r_pop <= n_pop;
    end

    assign o_top   = r_top;
    assign o_pop   = r_pop;
    assign o_count = r_cnt;

endmodule

@@ test/tb.sv @@
// Testbench for running_median_two_heaps: a queue-fed driver, a clocked monitor and a
// median predictor kept as a sorted list. Depends only on the block itself.
module tb;

    localparam int CAP = 64;
    localparam int LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_sample = '0;
    logic        i_restart = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_median;
    logic [6:0]  o_held_count;
    logic        o_dropped;

    typedef struct packed {
        logic [31:0] sample;
        logic        restart;
    } t_word_in;

    typedef struct packed {
        logic [31:0] median;
        logic [6:0]  held;
        logic        dropped;
    } t_word_out;

    t_word_in  pending_words[$];
    t_word_out expected_medians[$];
    logic signed [31:0] held_set[$];
    int  errors = 0;
    int  cycles = 0;
    int  accepted = 0;
    int  results = 0;
    int  drops = 0;
    bit  calm = 1'b0;
    bit  hold = 1'b0;

    running_median_two_heaps DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_sample(i_sample), .i_restart(i_restart), .o_valid(o_valid),
        .i_ready(i_ready), .o_median(o_median), .o_held_count(o_held_count),
        .o_dropped(o_dropped)
    );

    always #4 i_clk = ~i_clk;

    // The sorted held set gives the same median as the two heaps.
    function automatic t_word_out predict_median(t_word_in w);
        t_word_out r;
        logic signed [31:0] x;
        logic signed [32:0] sum;
        int n;
        int k;
        x = w.sample;
        r.dropped = 1'b0;
        if (w.restart) begin
            held_set.delete();
        end
        if (held_set.size() >= CAP) begin
            r.dropped = 1'b1;
        end else begin
            k = 0;
            while (k < held_set.size() && held_set[k] < x) k++;
            held_set.insert(k, x);
        end
        n = held_set.size();
        if (n % 2 == 1) begin
            r.median = held_set[n / 2];
        end else begin
            sum = 33'(held_set[n / 2 - 1]) + 33'(held_set[n / 2]);
            r.median = 32'((sum < 0) ? -((-sum) >>> 1) : (sum >>> 1));
        end
        r.held = 7'(n);
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_medians = {expected_medians,
                                    predict_median({i_sample, i_restart})};
                accepted <= accepted + 1;
            end
            if (!i_valid || o_ready) begin
                if (pending_words.size() > 0 && !hold &&
                        (calm || $urandom_range(99) >= 37)) begin
                    {i_sample, i_restart} <= pending_words.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= calm || ($urandom_range(99) >= 37);
        end
    end

    always @(posedge i_clk) begin
        t_word_out e;
        if (i_rst_n && o_valid && i_ready) begin
            results <= results + 1;
            if (expected_medians.size() == 0) begin
                $error("result with no expectation: median %0d", $signed(o_median));
                errors++;
            end else begin
                e = expected_medians.pop_front();
                if (e.dropped) drops <= drops + 1;
                if (o_median !== e.median) begin
                    $error("median expected %0d actual %0d", $signed(e.median),
                           $signed(o_median));
                    errors++;
                end
                if (o_held_count !== e.held) begin
                    $error("held_count expected %0d actual %0d", e.held, o_held_count);
                    errors++;
                end
                if (o_dropped !== e.dropped) begin
                    $error("dropped expected %0d actual %0d", e.dropped, o_dropped);
                    errors++;
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return 32'($urandom_range(8)) - 32'd4;
            3: return 32'($urandom_range(40));
            default: return $urandom;
        endcase
    endfunction

    task automatic push_word(logic [31:0] s, logic r);
        t_word_in w;
        w.sample = s;
        w.restart = r;
        pending_words = {pending_words, w};
    endtask

    initial begin
        int run;
        int j;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        push_word(32'h7FFF_FFFF, 1'b1);
        push_word(32'h7FFF_FFFF, 1'b0);
        push_word(32'h8000_0000, 1'b1);
        push_word(32'h8000_0000, 1'b0);
        push_word(32'h8000_0000, 1'b1);
        push_word(32'h7FFF_FFFF, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b1);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'h0000_0005, 1'b0);
        push_word(32'h0000_0005, 1'b0);
        push_word(32'hFFFF_FFFD, 1'b0);
        push_word(32'hFFFF_FFFA, 1'b0);
        push_word(32'hFFFF_FFFA, 1'b0);
        push_word(32'hAAAA_AAAA, 1'b0);
        push_word(32'h5555_5555, 1'b0);
        wait (pending_words.size() == 0 && expected_medians.size() == 0);
        calm = 1'b1;
        // Fill to capacity so the full case is hit repeatedly.
        push_word(rand_sample(), 1'b1);
        for (j = 0; j < CAP + 6; j++) push_word(rand_sample(), 1'b0);
        wait (pending_words.size() == 0 && expected_medians.size() == 0);
        calm = 1'b0;
        while (accepted < 1000) begin
            run = ($urandom_range(3) == 0) ? $urandom_range(CAP + 8, CAP / 2)
                                           : $urandom_range(12, 1);
            push_word(rand_sample(), 1'b1);
            for (j = 0; j < run; j++) push_word(rand_sample(), $urandom_range(40) == 0);
            if ($urandom_range(9) == 0) begin
                wait (pending_words.size() == 0);
                hold = 1'b1;
                wait (expected_medians.size() == 0 && !i_valid);
                hold = 1'b0;
            end
            wait (pending_words.size() < 4);
        end
        wait (pending_words.size() == 0 && !i_valid);
        wait (expected_medians.size() == 0);
        repeat (60) @(posedge i_clk);
        $display("Covered %0d samples with restarts, extremes, ties and full-set drops.",
                 accepted);
        $display("Checked %0d results, %0d of them dropped samples.", results, drops);
        if (errors == 0 && expected_medians.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
